// ----- hw/rtl/bmpdec_pkg.sv -----
// Package for the bitmap stream pixel decoder.
// Holds shared constants, the work descriptor passed from front to back, and result type.
// No dependencies.
package bmpdec_pkg;

	localparam int MaxDimDefault = 4096;
	localparam int FileHeaderBytes = 14;
	localparam int QueueDepthDefault = 4;

	localparam logic [15:0] SIGNATURE = 16'h4D42;
	localparam logic [31:0] CORE_HDR_SIZE = 32'd12;
	localparam logic [31:0] INFO_HDR_SIZE = 32'd40;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_SIGNATURE = 3'd1;
	localparam logic [2:0] ERR_HDR_SIZE = 3'd2;
	localparam logic [2:0] ERR_COMPRESSED = 3'd3;
	localparam logic [2:0] ERR_PALETTE = 3'd4;
	localparam logic [2:0] ERR_DEPTH = 3'd5;
	localparam logic [2:0] ERR_DIM = 3'd6;

	localparam logic [1:0] PH_HALT = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_PIXELS = 2'd2;
	localparam logic [1:0] PH_PAD = 2'd3;

	localparam logic [1:0] OP_ERROR = 2'd0;
	localparam logic [1:0] OP_MONO = 2'd1;
	localparam logic [1:0] OP_COLOUR = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  code;
		logic [7:0]  bits;
		logic [3:0]  count;
		logic [11:0] x;
		logic [11:0] y;
		logic        row_last;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
	} work_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  error_code;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        last;
	} result_t;

endpackage

// ----- hw/rtl/bmpdec_front.sv -----
// Front end: parses the header, tracks position, emits descriptors for pixels and errors.
// Depends on bmpdec_pkg.
module bmpdec_front import bmpdec_pkg::*; #(
	parameter int MAX_DIM = MaxDimDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] data_byte,
	input  logic       file_start,
	output logic       wr_valid,
	output work_t      wr_data
);

	logic [1:0]  phase_q;
	logic [5:0]  offset_q;
	logic        hkind_q;
	logic [31:0] shift_q;
	logic [12:0] width_q, height_q;
	logic [5:0]  bpp_q;
	logic [11:0] col_q, row_q;
	logic [1:0]  chan_q;
	logic [23:0] part_q;
	logic [1:0]  rbc_q;

	logic [1:0]  ph;
	logic [5:0]  off;
	logic [31:0] fs;
	logic [15:0] half;
	logic [12:0] w_d, h_d;
	logic [5:0]  bpp_d, dep;
	logic        hk_d;
	logic [1:0]  phase_d;
	logic [11:0] col_d, row_d;
	logic [1:0]  chan_d, rbc_d;
	logic [23:0] part_d;
	logic [12:0] remain, colnext;
	logic [3:0]  cnt;
	work_t       w;
	logic        emit;

	function automatic logic [12:0] dim_chk(input logic [31:0] v);
		if (v[31] || v == 32'd0 || v > 32'(MAX_DIM))
			return 13'd0;
		return v[12:0];
	endfunction

	always_comb begin
		ph = file_start ? PH_HEADER : phase_q;
		off = file_start ? 6'd0 : offset_q;
		hk_d = file_start ? 1'b0 : hkind_q;
		w_d = file_start ? 13'd0 : width_q;
		h_d = file_start ? 13'd0 : height_q;
		bpp_d = file_start ? 6'd0 : bpp_q;
		col_d = file_start ? 12'd0 : col_q;
		row_d = file_start ? 12'd0 : row_q;
		chan_d = file_start ? 2'd0 : chan_q;
		part_d = file_start ? 24'd0 : part_q;
		rbc_d = file_start ? 2'd0 : rbc_q;
		fs = {data_byte, (file_start ? 24'd0 : shift_q[31:8])};
		half = fs[31:16];
		phase_d = ph;
		dep = (half == 16'd1 || half == 16'd8 || half == 16'd24 || half == 16'd32)
			? half[5:0] : 6'd0;
		w = '0;
		w.alpha = 8'hFF;
		emit = 1'b0;
		remain = '0;
		colnext = '0;
		cnt = '0;
		case (ph)
			PH_HEADER: begin
				if (off == 6'd1) begin
					if (half != SIGNATURE) begin
						emit = 1'b1;
						w.code = ERR_SIGNATURE;
					end
				end else if (off == 6'(FileHeaderBytes + 3)) begin
					if (fs == CORE_HDR_SIZE)
						hk_d = 1'b0;
					else if (fs == INFO_HDR_SIZE)
						hk_d = 1'b1;
					else begin
						emit = 1'b1;
						w.code = ERR_HDR_SIZE;
					end
				end else if (off >= 6'(FileHeaderBytes + 4)) begin
					if (!hk_d) begin
						if (off == 6'd19)
							w_d = dim_chk({16'd0, half});
						else if (off == 6'd21)
							h_d = dim_chk({16'd0, half});
						else if (off == 6'd25)
							bpp_d = dep;
					end else begin
						if (off == 6'd21)
							w_d = dim_chk(fs);
						else if (off == 6'd25)
							h_d = dim_chk(fs);
						else if (off == 6'd29)
							bpp_d = dep;
						else if (off == 6'd33 && fs != 32'd0) begin
							emit = 1'b1;
							w.code = ERR_COMPRESSED;
						end else if (off == 6'd49 && fs != 32'd0) begin
							emit = 1'b1;
							w.code = ERR_PALETTE;
						end
					end
					if (!emit && ((!hk_d && off == 6'd25) || (hk_d && off == 6'd53))) begin
						if (bpp_d == 6'd0) begin
							emit = 1'b1;
							w.code = ERR_DEPTH;
						end else if (w_d == 13'd0 || h_d == 13'd0) begin
							emit = 1'b1;
							w.code = ERR_DIM;
						end else begin
							phase_d = PH_PIXELS;
							col_d = '0;
							row_d = '0;
							chan_d = '0;
							part_d = '0;
							rbc_d = '0;
						end
					end
				end
				if (emit) begin
					w.op = OP_ERROR;
					phase_d = PH_HALT;
				end
				off = off + 6'd1;
			end
			PH_PIXELS: begin
				rbc_d = rbc_d + 2'd1;
				w.x = col_d;
				w.y = 12'(h_d - 13'd1 - {1'b0, row_d});
				w.bits = data_byte;
				if (bpp_d == 6'd1) begin
					remain = w_d - {1'b0, col_d};
					cnt = (remain > 13'd8) ? 4'd8 : remain[3:0];
					w.op = OP_MONO;
					w.count = cnt;
					emit = 1'b1;
					colnext = {1'b0, col_d} + {9'd0, cnt};
				end else if (bpp_d == 6'd8) begin
					w.op = OP_COLOUR;
					w.red = data_byte;
					w.green = data_byte;
					w.blue = data_byte;
					emit = 1'b1;
					colnext = {1'b0, col_d} + 13'd1;
				end else if (chan_d < ((bpp_d == 6'd32) ? 2'd3 : 2'd2)) begin
					part_d = part_d | (24'(data_byte) << {chan_d, 3'b000});
					chan_d = chan_d + 2'd1;
				end else begin
					w.op = OP_COLOUR;
					w.red = part_d[7:0];
					w.green = part_d[15:8];
					w.blue = (bpp_d == 6'd32) ? part_d[23:16] : data_byte;
					w.alpha = (bpp_d == 6'd32) ? data_byte : 8'hFF;
					emit = 1'b1;
					colnext = {1'b0, col_d} + 13'd1;
					chan_d = '0;
					part_d = '0;
				end
				if (emit) begin
					w.row_last = ({1'b0, row_d} == h_d - 13'd1) && (colnext >= w_d);
					col_d = colnext[11:0];
					if (colnext >= w_d) begin
						col_d = '0;
						if ({1'b0, row_d} + 13'd1 >= h_d)
							phase_d = PH_HALT;
						else if (rbc_d != 2'd0)
							phase_d = PH_PAD;
						row_d = row_d + 12'd1;
					end
				end
			end
			PH_PAD: begin
				rbc_d = rbc_d + 2'd1;
				if (rbc_d == 2'd0)
					phase_d = PH_PIXELS;
			end
			default: ;
		endcase
	end

	assign wr_valid = in_valid && emit;
	assign wr_data = w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HALT;
			offset_q <= '0;
			hkind_q <= '0;
			shift_q <= '0;
			width_q <= '0;
			height_q <= '0;
			bpp_q <= '0;
			col_q <= '0;
			row_q <= '0;
			chan_q <= '0;
			part_q <= '0;
			rbc_q <= '0;
		end else if (in_valid) begin
			phase_q <= phase_d;
			offset_q <= off;
			hkind_q <= hk_d;
			shift_q <= (ph == PH_HEADER) ? fs : (file_start ? 32'd0 : shift_q);
			width_q <= w_d;
			height_q <= h_d;
			bpp_q <= bpp_d;
			col_q <= col_d;
			row_q <= row_d;
			chan_q <= chan_d;
			part_q <= part_d;
			rbc_q <= rbc_d;
		end
	end

endmodule

// ----- hw/rtl/bmpdec_queue.sv -----
// Small work queue between front and back end.
// Depends on bmpdec_pkg.
module bmpdec_queue import bmpdec_pkg::*; #(
	parameter int DEPTH = QueueDepthDefault
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  work_t wr_data,
	output logic  almost_full,
	output logic  rd_valid,
	input  logic  rd_en,
	output work_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	work_t           mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	// one slot stays back: almost_full rises at DEPTH - 1 entries
	assign almost_full = cnt_q >= (AW+1)'(DEPTH - 1);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

endmodule

// ----- hw/rtl/bmpdec_back.sv -----
// Back end: expands work descriptors into results, up to eight per descriptor at depth one.
// Depends on bmpdec_pkg.
module bmpdec_back import bmpdec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wk_valid,
	input  work_t   wk,
	input  logic    last_row_width_match,
	output logic    wk_pop,
	output logic    out_valid,
	output result_t out_data,
	input  logic    out_pop
);

	logic [3:0] idx_q;
	logic       oval_q;
	result_t    odat_q;
	logic       load;
	logic       done;
	result_t    r;
	logic [7:0] v;

	always_comb begin
		v = wk.bits[3'd7 - idx_q[2:0]] ? 8'hFF : 8'h00;
		r = '0;
		done = 1'b1;
		unique case (wk.op)
			OP_ERROR: begin
				r.kind = 1'b1;
				r.error_code = wk.code;
				r.last = 1'b1;
			end
			OP_MONO: begin
				r.pixel_x = wk.x + {8'd0, idx_q};
				r.pixel_y = wk.y;
				r.red = v;
				r.green = v;
				r.blue = v;
				r.alpha = 8'hFF;
				done = (idx_q + 4'd1) == wk.count;
				r.last = wk.row_last && done && last_row_width_match;
			end
			default: begin
				r.pixel_x = wk.x;
				r.pixel_y = wk.y;
				r.red = wk.red;
				r.green = wk.green;
				r.blue = wk.blue;
				r.alpha = wk.alpha;
				r.last = wk.row_last && last_row_width_match;
			end
		endcase
	end

	assign load = wk_valid && (!oval_q || out_pop);
	assign wk_pop = load && done;
	assign out_valid = oval_q;
	assign out_data = odat_q;

	always_ff @(posedge clk) begin
		if (load)
			odat_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			oval_q <= 1'b0;
		end else begin
			if (load)
				oval_q <= 1'b1;
			else if (out_pop)
				oval_q <= 1'b0;
			if (load)
				idx_q <= done ? 4'd0 : idx_q + 4'd1;
		end
	end

endmodule

// ----- hw/rtl/bmp_stream_pixel_decoder.sv -----
// Bitmap stream pixel decoder top level: front parser, work queue, result expander.
// Takes one byte per cycle while full is low; results pass the queue and output register;
// depth 1 gives up to eight results per byte, one per cycle while popped; input stalls.
// Asynchronous active-low reset returns the parser to waiting for a file start.
// Depends on bmpdec_pkg, bmpdec_front, bmpdec_queue, bmpdec_back.
module bmp_stream_pixel_decoder import bmpdec_pkg::*; #(
	parameter int MAX_DIM = MaxDimDefault,
	parameter int QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        file_start,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [2:0]  error_code,
	output logic [11:0] pixel_x,
	output logic [11:0] pixel_y,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last
);

	logic    wr_valid, afull, q_valid, q_pop, o_valid;
	work_t   wr_data, q_data;
	result_t res;

	bmpdec_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(push && !full),
		.data_byte(data_byte), .file_start(file_start),
		.wr_valid(wr_valid), .wr_data(wr_data)
	);

	bmpdec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_valid), .wr_data(wr_data),
		.almost_full(afull), .rd_valid(q_valid), .rd_en(q_pop), .rd_data(q_data)
	);

	bmpdec_back u_back (
		.clk(clk), .arst_n(arst_n), .wk_valid(q_valid), .wk(q_data),
		.last_row_width_match(1'b1), .wk_pop(q_pop),
		.out_valid(o_valid), .out_data(res), .out_pop(pop)
	);

	assign full = afull;
	assign empty = !o_valid;
	assign kind = res.kind;
	assign error_code = res.error_code;
	assign pixel_x = res.pixel_x;
	assign pixel_y = res.pixel_y;
	assign red = res.red;
	assign green = res.green;
	assign blue = res.blue;
	assign alpha = res.alpha;
	assign last = res.last;

endmodule

// ----- hw/rtl/bmpdec_checker.sv -----
// Port-level checker for the bitmap stream pixel decoder, bound to the top level.
// Depends on bmpdec_pkg and bmp_stream_pixel_decoder.
module bmpdec_checker import bmpdec_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [2:0]  error_code,
	input logic [11:0] pixel_x,
	input logic        last
);

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind |-> last) else $error("error transaction without last");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind |-> error_code != ERR_NONE) else $error("error code none");

	a_pix_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !kind |-> error_code == ERR_NONE) else $error("pixel with code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel_x)) else $error("result dropped");

endmodule

bind bmp_stream_pixel_decoder bmpdec_checker u_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .kind(kind),
	.error_code(error_code), .pixel_x(pixel_x), .last(last)
);
